// ----- rtl/gdad_pkg.sv -----
// Shared types, constants and calendar helpers for the date adder.
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

	// Field widths fixed by the interface
	localparam int DAY_FW   = 5;
	localparam int MONTH_FW = 4;
	localparam int YEAR_FW  = 14;
	localparam int OFFS_FW  = 16;

	// Working day count: start day plus offset, signed
	localparam int DAY_W = OFFS_FW + 1;

	// Month numbers
	localparam logic [MONTH_FW-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_FW-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_FW-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_FW-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_FW-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_FW-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_FW-1:0] MON_DEC = 4'd12;

	// Divisibility by 25 through the inverse of 25 modulo 2^32
	localparam logic [31:0] INV25     = 32'hC28F_5C29;
	localparam logic [31:0] DIV25_LIM = 32'h0A3D_70A3;

	// Microcode step counter
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_SETTL = 3'd1;
	localparam step_t STEP_CHECK = 3'd2;
	localparam step_t STEP_FWD   = 3'd3;
	localparam step_t STEP_BWD   = 3'd4;
	localparam step_t STEP_DONE  = 3'd5;
	localparam step_t STEP_SPR0  = 3'd6;
	localparam step_t STEP_SPR1  = 3'd7;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_NOP,
		OP_CHECK,
		OP_FWD,
		OP_BWD,
		OP_DONE
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_START,
		C_BAD,
		C_FWD,
		C_BWD
	} cond_t;

	// One control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump;
		step_t next;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		op_t op;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic bad;
		logic fwd_go;
		logic bwd_go;
	} stat_t;

	// Request payload
	typedef struct packed {
		logic [DAY_FW-1:0]          start_day;
		logic [MONTH_FW-1:0]        start_month;
		logic [YEAR_FW-1:0]         start_year;
		logic signed [OFFS_FW-1:0]  day_offset;
	} req_t;

	// Result payload
	typedef struct packed {
		logic [DAY_FW-1:0]   result_day;
		logic [MONTH_FW-1:0] result_month;
		logic [YEAR_FW-1:0]  result_year;
		logic                date_error;
	} res_t;

	// Days in a month given the leap flag of its year
	function automatic logic [DAY_FW-1:0] month_len(input logic [MONTH_FW-1:0] m,
		input logic leap);
		logic [DAY_FW-1:0] len;
		case (m) inside
			MON_FEB: begin
				len = leap ? 5'd29 : 5'd28;
			end
			MON_APR, MON_JUN, MON_SEP, MON_NOV: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	// Gregorian leap rule: by 4, not by 100 unless by 400
	function automatic logic is_leap(input logic [31:0] y);
		logic [31:0] prod;
		logic        div25;
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIM);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gregorian_date_add_days_top.sv -----
// Top level of the Gregorian date adder: sequencer plus date datapath.
//
// Usage: present a request (start date and signed day offset) and raise
// start. The request is taken at the rising edge where start is high and
// busy is low; busy then stays high until the walk is over. The result
// (day, month, year, date_error) appears on result for exactly one cycle
// with done high, and is taken at the edge that ends that cycle. The
// receiver cannot hold it off; busy is already low in that cycle, so a new
// request may be taken while the result is shown.
// The walk passes the settle and check steps, steps months forward, then
// backward, and ends in the done step: the month walk moves one month per
// cycle through a single add/compare datapath. An invalid start date goes
// from the check step straight to the done step.
// date_error is set, and the start date is returned, when the start date is
// invalid or the walk would leave years 1 to MAX_YEAR.
// Reset clears the step counter, the error flag and the done strobe; an
// item in flight is dropped.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days_top
	import gdad_pkg::*;
#(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	ctrl_t ctrl;
	stat_t stat;

	// Step counter and control store
	gdad_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Day, month and year walk
	gdad_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.ctrl    (ctrl),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while sequencer still busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_good_month: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.date_error |->
			result.result_month != 4'd0 && result.result_month <= 4'd12 &&
			result.result_day != 5'd0)
		else $error("valid result with out-of-range month or day");
`endif

endmodule

`default_nettype wire

// ----- rtl/gdad_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module gdad_seq
	import gdad_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire stat_t stat,
	output ctrl_t      ctrl,
	output logic       busy
);

	localparam int NSTEPS = 2 ** STEP_W;

	// Control store: op, condition, target when true, target when false
	localparam uword_t UCODE [NSTEPS] = '{
		'{op: OP_LOAD,  cond: C_START, jump: STEP_SETTL, next: STEP_IDLE},
		'{op: OP_NOP,   cond: C_NEVER, jump: STEP_IDLE,  next: STEP_CHECK},
		'{op: OP_CHECK, cond: C_BAD,   jump: STEP_DONE,  next: STEP_FWD},
		'{op: OP_FWD,   cond: C_FWD,   jump: STEP_FWD,   next: STEP_BWD},
		'{op: OP_BWD,   cond: C_BWD,   jump: STEP_BWD,   next: STEP_DONE},
		'{op: OP_DONE,  cond: C_NEVER, jump: STEP_IDLE,  next: STEP_IDLE},
		'{op: OP_NOP,   cond: C_NEVER, jump: STEP_IDLE,  next: STEP_IDLE},
		'{op: OP_NOP,   cond: C_NEVER, jump: STEP_IDLE,  next: STEP_IDLE}
	};

	step_t  step_q;
	step_t  step_d;
	uword_t word;
	logic   take;

	// Fetch the control word and pick the next step
	always_comb begin
		word = UCODE[step_q];
		case (word.cond)
			C_START: take = start;
			C_BAD:   take = stat.bad;
			C_FWD:   take = stat.fwd_go;
			C_BWD:   take = stat.bwd_go;
			default: take = 1'b0;
		endcase
		step_d  = take ? word.jump : word.next;
		ctrl.op = word.op;
		busy    = (step_q != STEP_IDLE);
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gdad_dp.sv -----
// Date datapath: day, month and year registers walked one month per step.
`timescale 1ns / 1ps
`default_nettype none

module gdad_dp
	import gdad_pkg::*;
#(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire req_t  request,
	input  wire ctrl_t ctrl,
	output stat_t      stat,
	output logic       done,
	output res_t       result
);

	// Year register holds both the full request field and MAX_YEAR + 1
	localparam int YEAR_W = ($clog2(MAX_YEAR + 2) > YEAR_FW) ? $clog2(MAX_YEAR + 2) : YEAR_FW;
	localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);
	localparam logic [YEAR_W-1:0] YONE = YEAR_W'(1);

	req_t                     req_q;
	logic signed [DAY_W-1:0]  d_q;
	logic [MONTH_FW-1:0]      m_q;
	logic [YEAR_W-1:0]        y_q;
	logic                     leap_q;
	logic                     err_q;
	logic                     done_q;
	res_t                     res_q;

	logic [DAY_FW-1:0]        len_cur;
	logic [DAY_FW-1:0]        len_dec;
	logic signed [DAY_W-1:0]  len_cur_s;
	logic signed [DAY_W-1:0]  len_dec_s;
	logic [MONTH_FW-1:0]      m_dec;
	logic                     m_bad;
	logic                     fwd_more;
	logic                     bwd_more;
	logic                     ovf;
	logic                     udf;

	// Sign-extend the stored offset to the day width
	function automatic logic signed [DAY_W-1:0] request_off(input req_t r);
		return {{(DAY_W-OFFS_FW){r.day_offset[OFFS_FW-1]}}, r.day_offset};
	endfunction

	// Month lengths of the current and the previous month, and the status flags
	always_comb begin
		m_dec     = (m_q == MON_JAN) ? MON_DEC : m_q - 4'd1;
		len_cur   = month_len(m_q, leap_q);
		len_dec   = month_len(m_dec, leap_q);
		len_cur_s = signed'({{(DAY_W-DAY_FW){1'b0}}, len_cur});
		len_dec_s = signed'({{(DAY_W-DAY_FW){1'b0}}, len_dec});
		m_bad     = (m_q == 4'd0) || (m_q > MON_DEC);
		fwd_more  = (d_q > len_cur_s);
		bwd_more  = (d_q < signed'(DAY_W'(1)));
		ovf       = (m_q == MON_DEC) && (y_q >= YMAX);
		udf       = (m_q == MON_JAN) && (y_q == YONE);
		stat.bad  = (y_q == '0) || (y_q > YMAX) || m_bad || bwd_more || fwd_more;
		stat.fwd_go = fwd_more && !ovf && !err_q;
		stat.bwd_go = bwd_more && !udf && !err_q;
	end

	// Track the leap flag of the current year through a register
	always_ff @(posedge clk) begin
		leap_q <= is_leap(32'(y_q));
	end

	// Walk the date under control of the sequencer
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (start) begin
					req_q <= request;
					d_q   <= signed'({{(DAY_W-DAY_FW){1'b0}}, request.start_day});
					m_q   <= request.start_month;
					y_q   <= YEAR_W'(request.start_year);
				end
			end
			OP_CHECK: begin
				if (!stat.bad) begin
					d_q <= d_q + DAY_W'(request_off(req_q));
				end
			end
			OP_FWD: begin
				if (!err_q && fwd_more && !ovf) begin
					d_q <= d_q - len_cur_s;
					if (m_q == MON_DEC) begin
						m_q <= MON_JAN;
						y_q <= y_q + YONE;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
			end
			OP_BWD: begin
				if (!err_q && bwd_more && !udf) begin
					d_q <= d_q + len_dec_s;
					m_q <= m_dec;
					if (m_q == MON_JAN) begin
						y_q <= y_q - YONE;
					end
				end
			end
			OP_DONE: begin
				if (err_q) begin
					res_q.result_day   <= req_q.start_day;
					res_q.result_month <= req_q.start_month;
					res_q.result_year  <= req_q.start_year;
				end else begin
					res_q.result_day   <= d_q[DAY_FW-1:0];
					res_q.result_month <= m_q;
					res_q.result_year  <= y_q[YEAR_FW-1:0];
				end
				res_q.date_error <= err_q;
			end
			default: begin
			end
		endcase
	end

	// Hold the error flag and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_DONE);
			case (ctrl.op)
				OP_LOAD: begin
					if (start) begin
						err_q <= 1'b0;
					end
				end
				OP_CHECK: begin
					if (stat.bad) begin
						err_q <= 1'b1;
					end
				end
				OP_FWD: begin
					if (fwd_more && ovf) begin
						err_q <= 1'b1;
					end
				end
				OP_BWD: begin
					if (bwd_more && udf) begin
						err_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire
